@@ rtl/fra_pkg.sv @@
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types, micro-operation codes and the control store for the
// fraction adder with greatest-common-divisor reduction.
// ----------------------------------------------------------------------------
package fra_pkg;

    typedef logic [3:0] t_step;
    typedef logic [3:0] t_op;
    typedef logic [3:0] t_cond;

    // Datapath micro-operations.
    localparam t_op OP_NOP     = 4'd0;
    localparam t_op OP_LOAD    = 4'd1;
    localparam t_op OP_MUL_A   = 4'd2;
    localparam t_op OP_MUL_B   = 4'd3;
    localparam t_op OP_MUL_C   = 4'd4;
    localparam t_op OP_INIT    = 4'd5;
    localparam t_op OP_SHR_AB  = 4'd6;
    localparam t_op OP_SHR_A   = 4'd7;
    localparam t_op OP_SHR_B   = 4'd8;
    localparam t_op OP_SUB     = 4'd9;
    localparam t_op OP_MK_G    = 4'd10;
    localparam t_op OP_DIV     = 4'd11;
    localparam t_op OP_PRESENT = 4'd12;

    // Branch conditions.
    localparam t_cond CND_ALWAYS    = 4'd0;
    localparam t_cond CND_IN_VALID  = 4'd1;
    localparam t_cond CND_NONZERO   = 4'd2;
    localparam t_cond CND_BOTH_EVEN = 4'd3;
    localparam t_cond CND_A_EVEN    = 4'd4;
    localparam t_cond CND_B_EVEN    = 4'd5;
    localparam t_cond CND_B_NZ      = 4'd6;
    localparam t_cond CND_CNT_NZ    = 4'd7;
    localparam t_cond CND_OUT_FREE  = 4'd8;

    // Program addresses.
    localparam t_step ST_IDLE   = 4'd0;
    localparam t_step ST_MUL_A  = 4'd1;
    localparam t_step ST_MUL_B  = 4'd2;
    localparam t_step ST_MUL_C  = 4'd3;
    localparam t_step ST_CHECK  = 4'd4;
    localparam t_step ST_INIT   = 4'd5;
    localparam t_step ST_TWOS   = 4'd6;
    localparam t_step ST_ODD_A  = 4'd7;
    localparam t_step ST_ODD_B  = 4'd8;
    localparam t_step ST_SUB    = 4'd9;
    localparam t_step ST_TEST_B = 4'd10;
    localparam t_step ST_MK_G   = 4'd11;
    localparam t_step ST_DIV    = 4'd12;
    localparam t_step ST_OUT    = 4'd13;

    // One control word: the operation runs and jt is taken when the
    // condition holds; otherwise nothing happens and jf is taken.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jt;
        t_step jf;
    } t_uword;

    typedef struct packed {
        logic nonzero;
        logic both_even;
        logic a_even;
        logic b_even;
        logic b_nz;
        logic cnt_nz;
        logic out_free;
    } t_flags;

    typedef struct packed {
        logic in_ready;
        t_op  op;
    } t_ctrl;

    function automatic t_uword rom_word(input t_step step);
        t_uword w;
        case (step)
            ST_IDLE:   w = '{OP_LOAD,    CND_IN_VALID,  ST_MUL_A,  ST_IDLE};
            ST_MUL_A:  w = '{OP_MUL_A,   CND_ALWAYS,    ST_MUL_B,  ST_MUL_B};
            ST_MUL_B:  w = '{OP_MUL_B,   CND_ALWAYS,    ST_MUL_C,  ST_MUL_C};
            ST_MUL_C:  w = '{OP_MUL_C,   CND_ALWAYS,    ST_CHECK,  ST_CHECK};
            ST_CHECK:  w = '{OP_NOP,     CND_NONZERO,   ST_INIT,   ST_OUT};
            ST_INIT:   w = '{OP_INIT,    CND_ALWAYS,    ST_TWOS,   ST_TWOS};
            ST_TWOS:   w = '{OP_SHR_AB,  CND_BOTH_EVEN, ST_TWOS,   ST_ODD_A};
            ST_ODD_A:  w = '{OP_SHR_A,   CND_A_EVEN,    ST_ODD_A,  ST_ODD_B};
            ST_ODD_B:  w = '{OP_SHR_B,   CND_B_EVEN,    ST_ODD_B,  ST_SUB};
            ST_SUB:    w = '{OP_SUB,     CND_ALWAYS,    ST_TEST_B, ST_TEST_B};
            ST_TEST_B: w = '{OP_NOP,     CND_B_NZ,      ST_ODD_B,  ST_MK_G};
            ST_MK_G:   w = '{OP_MK_G,    CND_ALWAYS,    ST_DIV,    ST_DIV};
            ST_DIV:    w = '{OP_DIV,     CND_CNT_NZ,    ST_DIV,    ST_OUT};
            ST_OUT:    w = '{OP_PRESENT, CND_OUT_FREE,  ST_IDLE,   ST_OUT};
            default:   w = '{OP_NOP,     CND_ALWAYS,    ST_IDLE,   ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/fraction_add_reduce.sv @@
// ----------------------------------------------------------------------------
// fraction_add_reduce
// Adds two non-negative fractions and reduces the sum by its greatest common
// divisor, under control of a small microprogram.
//
//   Channel  Dir  Beat contents (lowest bits first)
//   s_axis   in   first_numerator, first_denominator, second_numerator,
//                 second_denominator (OPERAND_BITS each)
//   m_axis   out  tdata: sum_numerator, sum_denominator; tuser: is_whole
//
// One operand beat is taken only when the sequencer is idle. An item passes
// through load, multiply, check and GCD set-up, then the binary GCD, then the
// set-up and run of the shift-subtract dividers, and then the output step. A
// zero numerator or denominator skips the reduction. The result register
// frees the sequencer unless a result is still waiting; then it holds at the
// output step. Reset is synchronous and returns the step counter to idle.
// ----------------------------------------------------------------------------
module fraction_add_reduce #(
    parameter int OPERAND_BITS = 15
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    // first_numerator, first_denominator, second_numerator, second_denominator
    input  logic [((4*OPERAND_BITS+7)/8)*8-1:0]       i_s_tdata,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    // sum_numerator, sum_denominator
    output logic [((4*OPERAND_BITS+8)/8)*8-1:0]       o_m_tdata,
    // is_whole
    output logic [0:0]                                o_m_tuser
);

    localparam int P     = OPERAND_BITS;
    localparam int OUT_W = ((4 * P + 8) / 8) * 8;

    fra_pkg::t_ctrl  ctrl;
    fra_pkg::t_flags flags;
    logic [2*P:0]    sum_num;
    logic [2*P-1:0]  sum_den;
    logic            is_whole;

    fra_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_flags    (flags),
        .o_ctrl     (ctrl)
    );

    fra_dpath #(
        .P (P)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_n1        (i_s_tdata[P-1:0]),
        .i_d1        (i_s_tdata[2*P-1:P]),
        .i_n2        (i_s_tdata[3*P-1:2*P]),
        .i_d2        (i_s_tdata[4*P-1:3*P]),
        .i_out_ready (i_m_tready),
        .o_flags     (flags),
        .o_out_valid (o_m_tvalid),
        .o_sum_num   (sum_num),
        .o_sum_den   (sum_den),
        .o_is_whole  (is_whole)
    );

    assign o_s_tready   = ctrl.in_ready;
    assign o_m_tdata    = OUT_W'({sum_den, sum_num});
    assign o_m_tuser[0] = is_whole;

    // A taken beat puts the sequencer to work at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("sequencer still idle after an operand beat");

    // The whole-number flag must agree with the denominator it goes with.
    a_whole_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] == (o_m_tdata[4*P:2*P+1] == (2*P)'(1))))
        else $error("is_whole disagrees with sum_denominator");

    // A new result is only ever written from the output step, never idle.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared while the sequencer was idle");

endmodule

@@ rtl/fra_useq.sv @@
// ----------------------------------------------------------------------------
// fra_useq
// Microprogram sequencer: step counter, control store and branch logic.
// ----------------------------------------------------------------------------
module fra_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  fra_pkg::t_flags i_flags,
    output fra_pkg::t_ctrl  o_ctrl
);

    fra_pkg::t_step  r_step;
    fra_pkg::t_step  n_step;
    fra_pkg::t_uword word;
    logic            hit;

    assign word = fra_pkg::rom_word(r_step);

    always_comb begin
        case (word.cond)
            fra_pkg::CND_ALWAYS:    hit = 1'b1;
            fra_pkg::CND_IN_VALID:  hit = i_in_valid;
            fra_pkg::CND_NONZERO:   hit = i_flags.nonzero;
            fra_pkg::CND_BOTH_EVEN: hit = i_flags.both_even;
            fra_pkg::CND_A_EVEN:    hit = i_flags.a_even;
            fra_pkg::CND_B_EVEN:    hit = i_flags.b_even;
            fra_pkg::CND_B_NZ:      hit = i_flags.b_nz;
            fra_pkg::CND_CNT_NZ:    hit = i_flags.cnt_nz;
            fra_pkg::CND_OUT_FREE:  hit = i_flags.out_free;
            default:                hit = 1'b0;
        endcase
    end

    assign n_step          = hit ? word.jt : word.jf;
    assign o_ctrl.op       = hit ? word.op : fra_pkg::OP_NOP;
    assign o_ctrl.in_ready = (r_step == fra_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= fra_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

@@ rtl/fra_dpath.sv @@
// ----------------------------------------------------------------------------
// fra_dpath
// Datapath: shared multiplier, binary GCD registers, a pair of restoring
// dividers sharing one divisor, and the result register.
// ----------------------------------------------------------------------------
module fra_dpath #(
    parameter int P = 15
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fra_pkg::t_ctrl  i_ctrl,
    input  logic [P-1:0]    i_n1,
    input  logic [P-1:0]    i_d1,
    input  logic [P-1:0]    i_n2,
    input  logic [P-1:0]    i_d2,
    input  logic            i_out_ready,
    output fra_pkg::t_flags o_flags,
    output logic            o_out_valid,
    output logic [2*P:0]    o_sum_num,
    output logic [2*P-1:0]  o_sum_den,
    output logic            o_is_whole
);

    localparam int NW = 2 * P + 1;
    localparam int DW = 2 * P;
    localparam int KW = $clog2(NW);
    localparam int CW = $clog2(NW + 1);

    logic [P-1:0]  r_n1, r_d1, r_n2, r_d2;
    logic [NW-1:0] r_num, r_den;
    logic [NW-1:0] r_a, r_b, r_g;
    logic [NW-1:0] r_rn, r_rd;
    logic [KW-1:0] r_k;
    logic [CW-1:0] r_cnt;
    logic          r_out_valid;
    logic [NW-1:0] r_out_num;
    logic [DW-1:0] r_out_den;
    logic          r_out_whole;

    logic [P-1:0]  mul_x, mul_y;
    logic [DW-1:0] mul_p;
    logic          a_gt_b;
    logic [NW-1:0] ab_diff;
    logic [NW-1:0] rn_sh, rd_sh;
    logic          rn_ge, rd_ge;

    always_comb begin
        case (i_ctrl.op)
            fra_pkg::OP_MUL_A: begin
                mul_x = r_n1;
                mul_y = r_d2;
            end
            fra_pkg::OP_MUL_B: begin
                mul_x = r_d1;
                mul_y = r_n2;
            end
            default: begin
                mul_x = r_d1;
                mul_y = r_d2;
            end
        endcase
    end

    assign mul_p   = DW'(mul_x) * DW'(mul_y);
    assign a_gt_b  = r_a > r_b;
    assign ab_diff = a_gt_b ? (r_a - r_b) : (r_b - r_a);

    // The remainder stays below the divisor, which fits in DW bits, so the
    // shifted remainder never loses its top bit.
    assign rn_sh = {r_rn[NW-2:0], r_num[NW-1]};
    assign rd_sh = {r_rd[NW-2:0], r_den[NW-1]};
    assign rn_ge = rn_sh >= r_g;
    assign rd_ge = rd_sh >= r_g;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            fra_pkg::OP_LOAD: begin
                r_n1 <= i_n1;
                r_d1 <= i_d1;
                r_n2 <= i_n2;
                r_d2 <= i_d2;
            end
            fra_pkg::OP_MUL_A: r_num <= NW'(mul_p);
            fra_pkg::OP_MUL_B: r_num <= r_num + NW'(mul_p);
            fra_pkg::OP_MUL_C: r_den <= NW'(mul_p);
            fra_pkg::OP_INIT: begin
                r_a <= r_num;
                r_b <= r_den;
                r_k <= '0;
            end
            fra_pkg::OP_SHR_AB: begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 1'b1;
            end
            fra_pkg::OP_SHR_A: r_a <= r_a >> 1;
            fra_pkg::OP_SHR_B: r_b <= r_b >> 1;
            fra_pkg::OP_SUB: begin
                // Both odd here: keep the smaller one, replace the other by
                // the difference, which is even.
                if (a_gt_b) begin
                    r_a <= r_b;
                end
                r_b <= ab_diff;
            end
            fra_pkg::OP_MK_G: begin
                r_g   <= r_a << r_k;
                r_rn  <= '0;
                r_rd  <= '0;
                r_cnt <= CW'(NW);
            end
            fra_pkg::OP_DIV: begin
                r_rn  <= rn_ge ? (rn_sh - r_g) : rn_sh;
                r_rd  <= rd_ge ? (rd_sh - r_g) : rd_sh;
                r_num <= {r_num[NW-2:0], rn_ge};
                r_den <= {r_den[NW-2:0], rd_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            fra_pkg::OP_PRESENT: begin
                r_out_num   <= r_num;
                r_out_den   <= r_den[DW-1:0];
                r_out_whole <= (r_den == NW'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.op == fra_pkg::OP_PRESENT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_flags.nonzero   = (r_num != '0) && (r_den != '0);
    assign o_flags.both_even = !r_a[0] && !r_b[0];
    assign o_flags.a_even    = !r_a[0];
    assign o_flags.b_even    = !r_b[0];
    assign o_flags.b_nz      = (r_b != '0);
    assign o_flags.cnt_nz    = (r_cnt != '0);
    assign o_flags.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_sum_num   = r_out_num;
    assign o_sum_den   = r_out_den;
    assign o_is_whole  = r_out_whole;

endmodule
